/* rtl/sism_pkg.sv */
`default_nettype none

package sism_pkg;

  // Store geometry.
  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Value, sum and mean widths.
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 38;
  localparam int FRAC_W = 8;
  localparam int MEAN_W = 40;

  // The divider works on the magnitude of sum * 2^FRAC_W.
  localparam int DIV_W  = SUM_W - 1 + FRAC_W;
  localparam int DCNT_W = $clog2(DIV_W);

  // Action codes.
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic                    action;
    logic signed [VAL_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic                     has_value;
    logic signed [VAL_W-1:0]  element;
    logic [CNT_W-1:0]         count;
    logic signed [MEAN_W-1:0] mean;
    logic                     full_error;
    logic                     last;
  } out_t;

endpackage

`default_nettype wire

/* rtl/sorted_insert_store_with_mean.sv */
// Insert: each stored value not less than the new one moves up one place, then
// the bit-serial divider (one quotient bit per cycle, 45 bits) forms the mean.
// An insert into a full store or a read of an empty store goes straight to emitting its result.
// Read out: each stored value is requested from the single registered read port, then emitted.
// One item is in work at a time; the input stalls until its results are queued.
// Reset clears the count, the sum, the mean, the state and the output valid flag.
`default_nettype none

module sorted_insert_store_with_mean
  import sism_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SCAN_RD  = 9'b000000010,
    ST_SCAN_CMP = 9'b000000100,
    ST_DIV_INIT = 9'b000001000,
    ST_DIV      = 9'b000010000,
    ST_MEAN     = 9'b000100000,
    ST_EMIT     = 9'b001000000,
    ST_RD_REQ   = 9'b010000000,
    ST_RD_DATA  = 9'b100000000
  } state_e;

  state_e                   state_q, state_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic signed [SUM_W-1:0]  sum_q, sum_d;
  logic signed [MEAN_W-1:0] mean_q, mean_d;
  logic [IDX_W-1:0]         idx_q, idx_d;
  logic signed [VAL_W-1:0]  val_q, val_d;
  logic                     err_q, err_d;
  logic [DIV_W-1:0]         div_q, div_d;
  logic [CNT_W-1:0]         rem_q, rem_d;
  logic [DCNT_W-1:0]        dcnt_q, dcnt_d;
  logic                     neg_q, neg_d;
  logic                     out_valid_q, out_valid_d;
  out_t                     out_q, out_d;

  // Value store: one write port, one registered read port.
  logic signed [VAL_W-1:0]  mem [CAPACITY];
  logic signed [VAL_W-1:0]  rdata_q;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_wa;
  logic signed [VAL_W-1:0]  mem_wd;

  // Divider datapath.
  logic [SUM_W-1:0]         sum_abs;
  logic [CNT_W:0]           trial;
  logic [CNT_W:0]           trial_diff;
  logic [MEAN_W-1:0]        quot;
  logic                     out_free;
  logic                     in_xfer;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign sum_abs    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign trial      = {rem_q, div_q[DIV_W-1]};
  assign trial_diff = trial - {1'b0, count_q};
  assign quot       = div_q[MEAN_W-1:0];

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    sum_d       = sum_q;
    mean_d      = mean_q;
    idx_d       = idx_q;
    val_d       = val_q;
    err_d       = err_q;
    div_d       = div_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_addr     = idx_q;
    mem_we      = 1'b0;
    mem_wa      = idx_q;
    mem_wd      = val_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          val_d = in_data_i.value;
          err_d = 1'b0;
          if (in_data_i.action == ACT_INSERT) begin
            if (count_q >= CNT_W'(CAPACITY)) begin
              err_d   = 1'b1;
              state_d = ST_EMIT;
            end else begin
              idx_d   = IDX_W'(count_q);
              state_d = ST_SCAN_RD;
            end
          end else if (count_q == '0) begin
            state_d = ST_EMIT;
          end else begin
            idx_d   = '0;
            state_d = ST_RD_REQ;
          end
        end
      end

      // Walk down from the top; values not less than the new one move up.
      ST_SCAN_RD: begin
        rd_addr = idx_q - IDX_W'(1);
        if (idx_q == '0) begin
          mem_we  = 1'b1;
          count_d = count_q + CNT_W'(1);
          sum_d   = sum_q + SUM_W'(val_q);
          state_d = ST_DIV_INIT;
        end else begin
          state_d = ST_SCAN_CMP;
        end
      end

      ST_SCAN_CMP: begin
        mem_we = 1'b1;
        if (rdata_q >= val_q) begin
          mem_wd  = rdata_q;
          idx_d   = idx_q - IDX_W'(1);
          state_d = ST_SCAN_RD;
        end else begin
          count_d = count_q + CNT_W'(1);
          sum_d   = sum_q + SUM_W'(val_q);
          state_d = ST_DIV_INIT;
        end
      end

      // Restoring division of |sum| * 2^FRAC_W by the count.
      ST_DIV_INIT: begin
        div_d   = {sum_abs[SUM_W-2:0], FRAC_W'(0)};
        neg_d   = sum_q[SUM_W-1];
        rem_d   = '0;
        dcnt_d  = DCNT_W'(DIV_W - 1);
        state_d = ST_DIV;
      end

      ST_DIV: begin
        if (trial >= {1'b0, count_q}) begin
          rem_d = trial_diff[CNT_W-1:0];
          div_d = {div_q[DIV_W-2:0], 1'b1};
        end else begin
          rem_d = trial[CNT_W-1:0];
          div_d = {div_q[DIV_W-2:0], 1'b0};
        end
        dcnt_d = dcnt_q - DCNT_W'(1);
        if (dcnt_q == '0) begin
          state_d = ST_MEAN;
        end
      end

      // Apply the sign; the quotient truncates toward zero.
      ST_MEAN: begin
        mean_d  = neg_q ? MEAN_W'(-quot) : MEAN_W'(quot);
        state_d = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.has_value  = 1'b0;
          out_d.element    = '0;
          out_d.count      = count_q;
          out_d.mean       = mean_q;
          out_d.full_error = err_q;
          out_d.last       = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      ST_RD_REQ: begin
        state_d = ST_RD_DATA;
      end

      ST_RD_DATA: begin
        if (out_free) begin
          out_valid_d      = 1'b1;
          out_d.has_value  = 1'b1;
          out_d.element    = rdata_q;
          out_d.count      = count_q;
          out_d.mean       = mean_q;
          out_d.full_error = 1'b0;
          out_d.last       = (CNT_W'(idx_q) + CNT_W'(1) == count_q);
          if (out_d.last) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + IDX_W'(1);
            state_d = ST_RD_REQ;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and running totals.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sum_q       <= '0;
      mean_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      mean_q      <= mean_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and the output payload.
  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    val_q  <= val_d;
    err_q  <= err_d;
    div_q  <= div_d;
    rem_q  <= rem_d;
    dcnt_q <= dcnt_d;
    neg_q  <= neg_d;
    out_q  <= out_d;
  end

  // Store write and registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_q <= mem[rd_addr];
  end

  // The count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("stored count exceeds capacity");

  // A dropped insert never carries an element.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.full_error |-> !out_data_o.has_value && out_data_o.last)
    else $error("full error result carries an element");

  // The divider only runs with a nonzero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> count_q != '0)
    else $error("division by a zero count");

  // Inserts write only within the occupied range plus one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> CNT_W'(mem_wa) <= count_q)
    else $error("store write beyond the count");

  // A new count shows up only after an insert finished its scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> state_q == ST_DIV_INIT)
    else $error("count changed outside an insert");

endmodule

`default_nettype wire
